// ----- sv/spimb_pkg.sv -----
// ----------------------------------------------------------------------------
// spimb_pkg
// Shared widths, register indexes and command codes of the SPI byte master.
// ----------------------------------------------------------------------------
package spimb_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HALF_W    = 7;
    localparam int unsigned BAUD_W    = 3;
    localparam int unsigned CFG_AW    = 4;
    localparam int unsigned APB_DW    = 32;

    localparam logic [BAUD_W-1:0] BAUD_RESET = 3'd7;

    // Register index as carried in paddr[3:2]
    typedef enum logic [1:0] {
        REG_BAUD_SELECT    = 2'd0,
        REG_CLOCK_POLARITY = 2'd1,
        REG_CLOCK_PHASE    = 2'd2,
        REG_LSB_FIRST      = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_select;
        logic              clock_polarity;
        logic              clock_phase;
        logic              lsb_first;
    } cfg_t;

endpackage

// ----- sv/spi_master_byte_transfer_core.sv -----
// Each accepted item's result is registered in the output register in the next cycle.
// Throughput: one item per cycle; the frame engine updates in a single pass.
// An item is taken whenever the output register is empty or drains that cycle.
// Reset (aresetn low, synchronous): engine idle, counters and shifters cleared,
// baud_select 7, polarity, phase and bit order 0, no result pending.
// ----------------------------------------------------------------------------
// spi_master_byte_transfer_core
// Full-duplex SPI master, clock modes 0 to 3; each item is a load or one peripheral tick.
// ----------------------------------------------------------------------------
module spi_master_byte_transfer_core #(
    parameter int unsigned FRAME_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spimb_pkg::CFG_AW-1:0]      paddr,
    input  logic [spimb_pkg::APB_DW-1:0]      pwdata,
    output logic [spimb_pkg::APB_DW-1:0]      prdata,
    output logic                              pready,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [spimb_pkg::BYTE_W-1:0]      s_tx_byte,
    input  logic                              s_miso_level,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_sck_level,
    output logic                              m_mosi_level,
    output logic                              m_busy_res,
    output logic                              m_rx_valid,
    output logic [spimb_pkg::BYTE_W-1:0]      m_rx_byte
);

    localparam int unsigned EDGES  = 2 * FRAME_BITS;
    localparam int unsigned EDGE_W = $clog2(EDGES);
    localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(EDGES - 1);

    // configuration
    spimb_pkg::cfg_t cfg_reg;
    spimb_pkg::cfg_t cfg_next;

    // frame engine
    logic [spimb_pkg::HALF_W-1:0] half_count_reg, half_count_next;
    logic [EDGE_W-1:0]            edge_count_reg, edge_count_next;
    logic [FRAME_BITS-1:0]        tx_shift_reg,   tx_shift_next;
    logic [FRAME_BITS-1:0]        rx_shift_reg,   rx_shift_next;
    logic                         active_reg,     active_next;
    logic                         clock_line_reg, clock_line_next;

    // output register
    logic                         m_valid_reg;
    logic                         m_sck_level_reg;
    logic                         m_mosi_level_reg;
    logic                         m_busy_res_reg;
    logic                         m_rx_valid_reg;
    logic [spimb_pkg::BYTE_W-1:0] m_rx_byte_reg;

    logic                         cfg_write;
    spimb_pkg::reg_idx_t          cfg_idx;
    logic                         in_fire;
    logic [FRAME_BITS-1:0]        tx_ext;
    logic [spimb_pkg::BYTE_W-1:0] rx_trunc;
    logic [spimb_pkg::BYTE_W:0]   half_span;
    logic [spimb_pkg::BYTE_W:0]   count_plus;
    logic                         edge_due;
    logic                         leading;
    logic                         last_edge;
    logic                         rx_valid_next;
    logic [spimb_pkg::BYTE_W-1:0] rx_byte_next;
    logic                         mosi_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = spimb_pkg::reg_idx_t'(paddr[3:2]);
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            spimb_pkg::REG_BAUD_SELECT:    prdata[spimb_pkg::BAUD_W-1:0] = cfg_reg.baud_select;
            spimb_pkg::REG_CLOCK_POLARITY: prdata[0] = cfg_reg.clock_polarity;
            spimb_pkg::REG_CLOCK_PHASE:    prdata[0] = cfg_reg.clock_phase;
            spimb_pkg::REG_LSB_FIRST:      prdata[0] = cfg_reg.lsb_first;
            default:                       prdata = '0;
        endcase
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_idx)
                spimb_pkg::REG_BAUD_SELECT:
                    cfg_next.baud_select = pwdata[spimb_pkg::BAUD_W-1:0];
                spimb_pkg::REG_CLOCK_POLARITY: cfg_next.clock_polarity = pwdata[0];
                spimb_pkg::REG_CLOCK_PHASE:    cfg_next.clock_phase    = pwdata[0];
                spimb_pkg::REG_LSB_FIRST:      cfg_next.lsb_first      = pwdata[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    // zero-extend or truncate the load byte to the frame, and the frame to a byte
    always_comb begin
        tx_ext = '0;
        for (int i = 0; i < FRAME_BITS; i++) begin
            if (i < spimb_pkg::BYTE_W) begin
                tx_ext[i] = s_tx_byte[i];
            end
        end
    end

    // report the frame including the bit sampled on the last edge
    always_comb begin
        rx_trunc = '0;
        for (int i = 0; i < spimb_pkg::BYTE_W; i++) begin
            if (i < FRAME_BITS) begin
                rx_trunc[i] = rx_shift_next[i];
            end
        end
    end

    assign half_span  = (spimb_pkg::BYTE_W + 1)'(1) << cfg_reg.baud_select;
    assign count_plus = (spimb_pkg::BYTE_W + 1)'(half_count_reg) + 1'b1;
    assign edge_due   = count_plus >= half_span;
    assign leading    = !edge_count_reg[0];
    assign last_edge  = edge_count_reg == LAST_EDGE;

    always_comb begin
        half_count_next = half_count_reg;
        edge_count_next = edge_count_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        active_next     = active_reg;
        clock_line_next = clock_line_reg;
        rx_valid_next   = 1'b0;

        if (in_fire) begin
            if (s_command == spimb_pkg::CMD_LOAD) begin
                // a load during a frame is dropped
                if (!active_reg) begin
                    tx_shift_next   = tx_ext;
                    rx_shift_next   = '0;
                    half_count_next = '0;
                    edge_count_next = '0;
                    clock_line_next = cfg_reg.clock_polarity;
                    active_next     = 1'b1;
                end
            end else if (active_reg) begin
                if (edge_due) begin
                    half_count_next = '0;
                    clock_line_next = !clock_line_reg;
                    if (leading == !cfg_reg.clock_phase) begin
                        // sample edge
                        if (cfg_reg.lsb_first) begin
                            rx_shift_next = {s_miso_level, rx_shift_reg[FRAME_BITS-1:1]};
                        end else begin
                            rx_shift_next = {rx_shift_reg[FRAME_BITS-2:0], s_miso_level};
                        end
                    end else if ((leading && edge_count_reg != '0) ||
                                 (!leading && !last_edge)) begin
                        // shift edge; the first bit is already on the line
                        if (cfg_reg.lsb_first) begin
                            tx_shift_next = {1'b0, tx_shift_reg[FRAME_BITS-1:1]};
                        end else begin
                            tx_shift_next = {tx_shift_reg[FRAME_BITS-2:0], 1'b0};
                        end
                    end
                    if (last_edge) begin
                        active_next     = 1'b0;
                        edge_count_next = '0;
                        clock_line_next = cfg_reg.clock_polarity;
                        rx_valid_next   = 1'b1;
                    end else begin
                        edge_count_next = edge_count_reg + 1'b1;
                    end
                end else begin
                    half_count_next = half_count_reg + 1'b1;
                end
            end else begin
                clock_line_next = cfg_reg.clock_polarity;
            end
        end else if (cfg_write && !active_reg) begin
            // idle clock follows the polarity register
            clock_line_next = cfg_next.clock_polarity;
        end
    end

    assign rx_byte_next = rx_valid_next ? rx_trunc : '0;
    assign mosi_next = cfg_reg.lsb_first ? tx_shift_next[0] : tx_shift_next[FRAME_BITS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baud_select    <= spimb_pkg::BAUD_RESET;
            cfg_reg.clock_polarity <= 1'b0;
            cfg_reg.clock_phase    <= 1'b0;
            cfg_reg.lsb_first      <= 1'b0;
            half_count_reg         <= '0;
            edge_count_reg         <= '0;
            tx_shift_reg           <= '0;
            rx_shift_reg           <= '0;
            active_reg             <= 1'b0;
            clock_line_reg         <= 1'b0;
            m_valid_reg            <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            half_count_reg <= half_count_next;
            edge_count_reg <= edge_count_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            active_reg     <= active_next;
            clock_line_reg <= clock_line_next;
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_sck_level_reg  <= clock_line_next;
            m_mosi_level_reg <= mosi_next;
            m_busy_res_reg   <= active_next;
            m_rx_valid_reg   <= rx_valid_next;
            m_rx_byte_reg    <= rx_byte_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sck_level  = m_sck_level_reg;
    assign m_mosi_level = m_mosi_level_reg;
    assign m_busy_res   = m_busy_res_reg;
    assign m_rx_valid   = m_rx_valid_reg;
    assign m_rx_byte    = m_rx_byte_reg;

    a_done_not_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_rx_valid_reg |-> !m_busy_res_reg)
        else $error("frame completion reported while still busy");

    a_rx_zero_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_rx_valid_reg |-> m_rx_byte_reg == '0)
        else $error("received byte nonzero without completion");

    a_idle_counters : assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> edge_count_reg == '0 && half_count_reg == '0)
        else $error("counters not cleared while idle");

    a_idle_clock : assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> clock_line_reg == cfg_reg.clock_polarity)
        else $error("idle serial clock differs from polarity");

    a_load_starts : assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_command == spimb_pkg::CMD_LOAD && !active_reg |=> active_reg)
        else $error("load while idle did not start a frame");

endmodule
